// ----- hw/rtl/pfd_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pfd_pkg
// Shared types, constants and character mapping functions for the 8x8
// Playfair digraph cipher core.
// ---------------------------------------------------------------------------
package pfd_pkg;

	localparam int unsigned SIDE_W     = 3;
	localparam int unsigned INDEX_W    = 2 * SIDE_W;
	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [INDEX_W-1:0] PAD_INDEX    = 6'd49;
	localparam logic [7:0]         NEWLINE_BYTE = 8'h0A;

	typedef logic [INDEX_W-1:0] pfd_index_t;

	typedef struct packed {
		logic       found;
		pfd_index_t index;
	} pfd_lookup_t;

	typedef struct packed {
		logic       last;
		logic [7:0] second_char;
		logic [7:0] first_char;
	} pfd_result_t;

	// Maps an ASCII byte onto its square position.
	function automatic pfd_lookup_t index_of(input logic [7:0] b);
		pfd_lookup_t r;
		logic [7:0]  d;
		r.found = 1'b0;
		r.index = '0;
		d       = '0;
		if (b >= 8'h61 && b <= 8'h7A) begin
			d       = b - 8'h61;
			r.found = 1'b1;
			r.index = d[INDEX_W-1:0];
		end else if (b >= 8'h41 && b <= 8'h5A) begin
			d       = b - 8'h41 + 8'd26;
			r.found = 1'b1;
			r.index = d[INDEX_W-1:0];
		end else if (b >= 8'h30 && b <= 8'h39) begin
			d       = b - 8'h30 + 8'd52;
			r.found = 1'b1;
			r.index = d[INDEX_W-1:0];
		end else if (b == 8'h40) begin
			r.found = 1'b1;
			r.index = 6'd62;
		end else if (b == 8'h5F) begin
			r.found = 1'b1;
			r.index = 6'd63;
		end
		return r;
	endfunction

	// Maps a square position back to its ASCII character.
	function automatic logic [7:0] char_of(input pfd_index_t idx);
		logic [7:0] w;
		logic [7:0] c;
		w = {2'b00, idx};
		if (idx < 6'd26) begin
			c = w + 8'h61;
		end else if (idx < 6'd52) begin
			c = w - 8'd26 + 8'h41;
		end else if (idx < 6'd62) begin
			c = w - 8'd52 + 8'h30;
		end else if (idx == 6'd62) begin
			c = 8'h40;
		end else begin
			c = 8'h5F;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pfd_digraph.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pfd_digraph
// Enciphers one digraph of square positions into two ASCII characters.
// ---------------------------------------------------------------------------
module pfd_digraph
	import pfd_pkg::*;
(
	input  wire pfd_index_t a,
	input  wire pfd_index_t b,
	output logic [7:0]      first_char,
	output logic [7:0]      second_char
);

	logic [SIDE_W-1:0] r1, c1, r2, c2;
	pfd_index_t        x, y;

	assign r1 = a[INDEX_W-1:SIDE_W];
	assign c1 = a[SIDE_W-1:0];
	assign r2 = b[INDEX_W-1:SIDE_W];
	assign c2 = b[SIDE_W-1:0];

	// Row and column fields wrap naturally at the square side.
	always_comb begin
		if (r1 == r2) begin
			x = {r1, c1 + 1'b1};
			y = {r2, c2 + 1'b1};
		end else if (c1 == c2) begin
			x = {r1 + 1'b1, c1};
			y = {r2 + 1'b1, c2};
		end else begin
			x = {r1, c2};
			y = {r2, c1};
		end
	end

	assign first_char  = char_of(x);
	assign second_char = char_of(y);

endmodule
`default_nettype wire

// ----- hw/rtl/pfd_result_fifo.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pfd_result_fifo
// Small result queue that takes up to two results per cycle and gives one.
// ---------------------------------------------------------------------------
module pfd_result_fifo
	import pfd_pkg::*;
(
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire  [1:0]               push_n,
	input  wire  pfd_result_t        push_data0,
	input  wire  pfd_result_t        push_data1,
	input  wire                      pop,
	output logic                     head_valid,
	output pfd_result_t              head_data,
	output logic [FIFO_CW-1:0]       count
);

	pfd_result_t        mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               do_pop;

	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign count      = count_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_data0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= push_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FIFO_CW'(push_n) - FIFO_CW'(do_pop);
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/playfair_digraph_cipher_8x8_core.sv -----
`default_nettype none
// A byte is registered in the input stage; its results then go into the queue.
// Throughput: one input byte per cycle while ready is high; a byte that yields
// two digraphs pushes two results, which the eight-entry result queue absorbs.
// Input ready depends only on queue occupancy and the registered input stage.
// Reset (arst_n low) clears the pending letter, the newline flag and the queue.
// ---------------------------------------------------------------------------
// playfair_digraph_cipher_8x8_core
// Streaming Playfair encoder on a fixed 8x8 square of a-z, A-Z, 0-9, @, _.
// ---------------------------------------------------------------------------
module playfair_digraph_cipher_8x8_core
	import pfd_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] byte_in
	input  wire         s_axis_tlast,   // end_of_message
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] first_char, [15:8] second_char
	output logic        m_axis_tlast    // message_end
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               eom_s1;

	logic               pend_valid_q;
	pfd_index_t         pend_index_q;
	logic               stopped_q;

	pfd_lookup_t        lk;
	logic               kept;
	logic               pair_now;
	logic               nv_valid;
	pfd_index_t         nv_index;
	logic               flush;
	pfd_index_t         second_idx;

	logic [7:0]         a_first, a_second, b_first, b_second;
	pfd_result_t        res_a, res_b;
	logic [1:0]         push_n;
	pfd_result_t        push0, push1;
	logic               head_valid;
	pfd_result_t        head_data;
	logic [FIFO_CW-1:0] fifo_count;
	logic [FIFO_CW:0]   committed;

	// Room for this request and the one in the input stage, two results each.
	assign committed     = {1'b0, fifo_count} + (valid_s1 ? (FIFO_CW+1)'(2) : '0);
	assign s_axis_tready = (committed <= (FIFO_CW+1)'(FIFO_DEPTH / 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_axis_tvalid && s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eom_s1  <= s_axis_tlast;
		end
	end

	always_comb begin
		lk         = index_of(byte_s1);
		kept       = valid_s1 && !stopped_q && (byte_s1 != NEWLINE_BYTE) && lk.found;
		pair_now   = kept && pend_valid_q;
		second_idx = (lk.index == pend_index_q) ? PAD_INDEX : lk.index;
		nv_valid   = pend_valid_q;
		nv_index   = pend_index_q;
		if (kept && !pend_valid_q) begin
			nv_valid = 1'b1;
			nv_index = lk.index;
		end else if (pair_now && (lk.index != pend_index_q)) begin
			nv_valid = 1'b0;
		end
		flush = valid_s1 && eom_s1 && nv_valid;
	end

	pfd_digraph u_pair (
		.a           (pend_index_q),
		.b           (second_idx),
		.first_char  (a_first),
		.second_char (a_second)
	);

	pfd_digraph u_flush (
		.a           (nv_index),
		.b           (PAD_INDEX),
		.first_char  (b_first),
		.second_char (b_second)
	);

	always_comb begin
		res_a.first_char  = a_first;
		res_a.second_char = a_second;
		res_a.last        = eom_s1 && !flush;
		res_b.first_char  = b_first;
		res_b.second_char = b_second;
		res_b.last        = 1'b1;
		push_n            = {1'b0, pair_now} + {1'b0, flush};
		push0             = pair_now ? res_a : res_b;
		push1             = res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_index_q <= '0;
			stopped_q    <= 1'b0;
		end else if (valid_s1) begin
			if (eom_s1) begin
				pend_valid_q <= 1'b0;
				pend_index_q <= '0;
				stopped_q    <= 1'b0;
			end else begin
				pend_valid_q <= nv_valid;
				pend_index_q <= nv_index;
				if (byte_s1 == NEWLINE_BYTE) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	pfd_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_data0 (push0),
		.push_data1 (push1),
		.pop        (m_axis_tready),
		.head_valid (head_valid),
		.head_data  (head_data),
		.count      (fifo_count)
	);

	assign m_axis_tvalid = head_valid;
	assign m_axis_tdata  = {head_data.second_char, head_data.first_char};
	assign m_axis_tlast  = head_data.last;

endmodule
`default_nettype wire

// ----- dv/playfair_digraph_cipher_8x8_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// playfair_digraph_cipher_8x8_core_tb
// Streams plaintext bytes into the Playfair core with random gaps and output
// stalls. Each accepted byte is run through a local cipher model, and every
// digraph that comes out is checked in order against the predicted one.
// ---------------------------------------------------------------------------
module playfair_digraph_cipher_8x8_core_tb;
	import pfd_pkg::*;

	localparam logic [8*64-1:0] SQUARE_TEXT =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789@_";
	localparam int unsigned RANDOM_BYTES   = 850;
	localparam int unsigned CALM_TAIL      = 150;
	localparam int unsigned STALL_LIMIT    = 1000;
	localparam int unsigned SETTLE_CYCLES  = 20;
	localparam int unsigned REPORT_MAX     = 10;

	typedef struct {
		logic [7:0]  data;
		logic        eom;
		int unsigned gap;
		bit          hold_off;
	} plain_req_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] byte_in
	logic        s_axis_tlast  = 1'b0;   // end_of_message
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [15:0] m_axis_tdata;           // [7:0] first_char, [15:8] second_char
	wire         m_axis_tlast;           // message_end

	plain_req_t  plain_q[$];
	pfd_result_t ciphertext_q[$];

	// Local copy of the cipher state.
	bit          held_valid   = 1'b0;
	logic [5:0]  held_index   = '0;
	bit          newline_seen = 1'b0;

	plain_req_t  staged_req;
	bit          staged      = 1'b0;
	int unsigned gap_left    = 0;
	int unsigned stall_left  = 0;
	int unsigned quiet_left  = 0;
	int unsigned mismatches  = 0;
	int unsigned idle_cycles = 0;
	int unsigned bytes_made  = 0;

	playfair_digraph_cipher_8x8_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #4 clk = ~clk;

	function automatic logic [7:0] glyph(input logic [5:0] idx);
		int k;
		k = 63 - int'(idx);
		return SQUARE_TEXT[8*k +: 8];
	endfunction

	// Square position of a byte, or -1 when the byte is not in the alphabet.
	function automatic int square_pos(input logic [7:0] b);
		int pos;
		pos = -1;
		for (int k = 0; k < 64; k++) begin
			if (glyph(k[5:0]) == b) begin
				pos = k;
			end
		end
		return pos;
	endfunction

	function automatic pfd_result_t encipher_pair(input logic [5:0] a, input logic [5:0] b);
		logic [2:0]  ra, ca, rb, cb;
		logic [5:0]  x, y;
		pfd_result_t r;
		ra = a[5:3];
		ca = a[2:0];
		rb = b[5:3];
		cb = b[2:0];
		// The row rule is checked first, so a doubled letter shifts right.
		if (ra == rb) begin
			x = {ra, 3'(ca + 3'd1)};
			y = {rb, 3'(cb + 3'd1)};
		end else if (ca == cb) begin
			x = {3'(ra + 3'd1), ca};
			y = {3'(rb + 3'd1), cb};
		end else begin
			x = {ra, cb};
			y = {rb, ca};
		end
		r.first_char  = glyph(x);
		r.second_char = glyph(y);
		r.last        = 1'b0;
		return r;
	endfunction

	task automatic encipher_byte(input logic [7:0] b, input logic eom);
		pfd_result_t digraph [2];
		int          n;
		int          pos;
		n   = 0;
		pos = square_pos(b);
		if (!newline_seen) begin
			if (b == NEWLINE_BYTE) begin
				newline_seen = 1'b1;
			end else if (pos >= 0) begin
				if (!held_valid) begin
					held_valid = 1'b1;
					held_index = pos[5:0];
				end else if (pos[5:0] == held_index) begin
					// The repeated letter stays held after the padded digraph.
					digraph[n] = encipher_pair(held_index, PAD_INDEX);
					n++;
				end else begin
					digraph[n] = encipher_pair(held_index, pos[5:0]);
					n++;
					held_valid = 1'b0;
				end
			end
		end
		if (eom) begin
			if (held_valid) begin
				digraph[n] = encipher_pair(held_index, PAD_INDEX);
				n++;
			end
			if (n > 0) begin
				digraph[n-1].last = 1'b1;
			end
			held_valid   = 1'b0;
			held_index   = '0;
			newline_seen = 1'b0;
		end
		for (int k = 0; k < n; k++) begin
			ciphertext_q.insert(ciphertext_q.size(), digraph[k]);
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic eom, input int unsigned gap,
			input bit hold_off);
		plain_req_t r;
		r.data     = b;
		r.eom      = eom;
		r.gap      = gap;
		r.hold_off = hold_off;
		plain_q.insert(plain_q.size(), r);
		bytes_made++;
	endtask

	task automatic note_mismatch(input pfd_result_t want, input pfd_result_t got, input bit stray);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			if (stray) begin
				$display("%0t: unexpected digraph first=%h second=%h last=%b",
					$realtime, got.first_char, got.second_char, got.last);
			end else begin
				$display({"%0t: digraph mismatch: expected first=%h second=%h last=%b,",
					" got first=%h second=%h last=%b"},
					$realtime, want.first_char, want.second_char, want.last,
					got.first_char, got.second_char, got.last);
			end
		end
	endtask

	// Driver: presents queued bytes, honoring per-byte gaps and drain holds.
	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
			s_axis_tlast  <= 1'b0;
		end else begin
			next_valid = 1'b0;
			if (s_axis_tvalid && !s_axis_tready) begin
				next_valid = 1'b1;
			end else begin
				if (s_axis_tvalid) begin
					encipher_byte(s_axis_tdata, s_axis_tlast);
				end
				if (!staged && plain_q.size() != 0) begin
					staged_req = plain_q.pop_front();
					staged     = 1'b1;
					gap_left   = staged_req.gap;
				end
				if (staged) begin
					if (gap_left != 0) begin
						gap_left--;
					end else if (!staged_req.hold_off || ciphertext_q.size() == 0) begin
						s_axis_tdata <= staged_req.data;
						s_axis_tlast <= staged_req.eom;
						next_valid   = 1'b1;
						staged       = 1'b0;
					end
				end
			end
			s_axis_tvalid <= next_valid;
		end
	end

	// Monitor: random output stalls and in-order digraph checking.
	always @(posedge clk or negedge arst_n) begin
		pfd_result_t want;
		pfd_result_t got;
		logic        ready;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.first_char  = m_axis_tdata[7:0];
				got.second_char = m_axis_tdata[15:8];
				got.last        = m_axis_tlast;
				if (ciphertext_q.size() == 0) begin
					want = '0;
					note_mismatch(want, got, 1'b1);
				end else begin
					want = ciphertext_q.pop_front();
					if (got.first_char != want.first_char ||
							got.second_char != want.second_char ||
							got.last != want.last) begin
						note_mismatch(want, got, 1'b0);
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				ready = 1'b0;
			end else begin
				ready = 1'b1;
				if (quiet_left != 0) begin
					quiet_left--;
				end else if (plain_q.size() > CALM_TAIL) begin
					if ($urandom_range(0, 15) == 0) begin
						quiet_left = $urandom_range(20, 60);
					end else if ($urandom_range(0, 5) == 0) begin
						stall_left = $urandom_range(1, 10);
					end
				end
			end
			m_axis_tready <= ready;
		end
	end

	// Watchdog on cycles with no request accepted on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL playfair_digraph_cipher_8x8_core");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned len;
		int unsigned msg_no;
		int unsigned pick;
		int unsigned gap;
		bit          gappy;
		bit          noisy;
		logic [7:0]  b;
		logic [7:0]  prev;

		// Same row, same column, and rectangle digraphs.
		add_byte("a", 1'b0, 0, 1'b0);
		add_byte("b", 1'b0, 0, 1'b0);
		add_byte("a", 1'b0, 0, 1'b0);
		add_byte("i", 1'b0, 0, 1'b0);
		add_byte("_", 1'b0, 0, 1'b0);
		add_byte("0", 1'b0, 0, 1'b0);
		// A space is skipped; a doubled letter at end of message yields two digraphs.
		add_byte(" ", 1'b0, 0, 1'b0);
		add_byte("c", 1'b0, 0, 1'b0);
		add_byte("c", 1'b1, 0, 1'b0);
		// End of message on a skipped byte with nothing held gives nothing.
		add_byte(8'h00, 1'b1, 0, 1'b0);
		// The pad letter alone flushes as a doubled pair.
		add_byte("X", 1'b1, 0, 1'b0);
		// After a newline the rest of the message is ignored, but the held letter flushes.
		add_byte("q", 1'b0, 0, 1'b0);
		add_byte(NEWLINE_BYTE, 1'b0, 0, 1'b0);
		add_byte("r", 1'b0, 0, 1'b0);
		add_byte(8'hFF, 1'b1, 0, 1'b0);
		add_byte(8'h80, 1'b0, 0, 1'b0);
		add_byte("@", 1'b0, 0, 1'b0);
		add_byte("7", 1'b1, 0, 1'b0);
		add_byte(8'hFF, 1'b0, 0, 1'b0);
		add_byte("z", 1'b1, 0, 1'b0);
		add_byte(NEWLINE_BYTE, 1'b1, 0, 1'b0);
		add_byte(8'h7F, 1'b0, 0, 1'b0);
		add_byte("A", 1'b0, 0, 1'b0);
		add_byte("A", 1'b0, 0, 1'b0);
		add_byte("B", 1'b1, 0, 1'b0);

		bytes_made = 0;
		msg_no     = 0;
		while (bytes_made < RANDOM_BYTES) begin
			len = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			gappy = ($urandom_range(0, 2) != 0) && (bytes_made + CALM_TAIL < RANDOM_BYTES);
			noisy = ($urandom_range(0, 9) == 0);
			prev  = "a";
			for (int k = 0; k < len; k++) begin
				pick = $urandom_range(0, 99);
				if (noisy) begin
					b = 8'($urandom_range(0, 255));
				end else if (pick < 10 && k > 0) begin
					b = prev;
				end else if (pick < 16) begin
					b = " ";
				end else if (pick < 19) begin
					b = NEWLINE_BYTE;
				end else if (pick < 25) begin
					b = 8'($urandom_range(0, 255));
				end else begin
					b = glyph(6'($urandom_range(0, 63)));
				end
				gap = (gappy && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
				// Every so often a message waits for all earlier digraphs to drain.
				add_byte(b, k == len - 1, gap, k == 0 && msg_no % 25 == 0);
				prev = b;
			end
			msg_no++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (plain_q.size() != 0 || staged || s_axis_tvalid) begin
			@(posedge clk);
		end
		while (ciphertext_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && ciphertext_q.size() == 0) begin
			$display("PASS playfair_digraph_cipher_8x8_core");
		end else begin
			$display("FAIL playfair_digraph_cipher_8x8_core");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/pfd_pkg.sv
hw/rtl/pfd_digraph.sv
hw/rtl/pfd_result_fifo.sv
hw/rtl/playfair_digraph_cipher_8x8_core.sv
dv/playfair_digraph_cipher_8x8_core_tb.sv
